### rtl/core/safe_pkg.sv
package safe_pkg;

  // Bit positions of the condition flags in the status word
  localparam int unsigned FlagN = 31;
  localparam int unsigned FlagZ = 30;
  localparam int unsigned FlagC = 29;
  localparam int unsigned FlagV = 28;

  localparam logic [3:0] RegPc = 4'd15;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_kind_t;

  // Shifter stage to ALU stage
  typedef struct packed {
    alu_op_t     opcode;
    logic        s_bit;
    logic [3:0]  rd;
    logic [31:0] rn;
    logic [31:0] op;
    logic        sc;
    logic [31:0] status;
    logic [31:0] saved;
    logic        has_saved;
  } shift_stage_t;

  // ALU stage to flag stage
  typedef struct packed {
    logic        test;
    logic        s_bit;
    logic [3:0]  rd;
    logic [31:0] res;
    logic        c;
    logic        v;
    logic [31:0] status;
    logic [31:0] saved;
    logic        has_saved;
  } alu_stage_t;

endpackage

### rtl/core/safe_in_if.sv
interface safe_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr;
  logic [31:0] rn_data;
  logic [31:0] rm_data;
  logic [31:0] rs_data;
  logic [31:0] status_in;
  logic [31:0] saved_status;
  logic        mode_has_saved;

  modport source (
    output valid, instr, rn_data, rm_data, rs_data, status_in, saved_status,
           mode_has_saved,
    input  ready
  );

  modport sink (
    input  valid, instr, rn_data, rm_data, rs_data, status_in, saved_status,
           mode_has_saved,
    output ready
  );
endinterface

### rtl/core/safe_out_if.sv
interface safe_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  dest_index;
  logic [31:0] dest_value;
  logic        dest_write;
  logic [31:0] status_out;
  logic        status_write;

  modport source (
    output valid, dest_index, dest_value, dest_write, status_out, status_write,
    input  ready
  );

  modport sink (
    input  valid, dest_index, dest_value, dest_write, status_out, status_write,
    output ready
  );
endinterface

### rtl/core/safe_shift.sv
module safe_shift (
  input  logic                   clk,
  input  logic                   rst,
  safe_in_if.sink                in_ch,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output safe_pkg::shift_stage_t dn
);

  safe_pkg::shift_stage_t  dn_next;
  safe_pkg::shift_kind_t   kind;
  logic                    cin;
  logic [4:0]              imm_amt;
  logic [7:0]              rs_amt;
  logic [5:0]              amt;
  logic                    keep;
  logic                    rrx;
  logic                    over;
  logic [63:0]             lsl_t;
  logic [63:0]             lsr_t;
  logic [63:0]             asr_t;
  logic [63:0]             ror_t;
  logic [63:0]             imm_t;
  logic [31:0]             op;
  logic                    sc;

  // Decode the shift amount and its special encodings
  always_comb begin
    kind    = safe_pkg::shift_kind_t'(in_ch.instr[6:5]);
    cin     = in_ch.status_in[safe_pkg::FlagC];
    imm_amt = in_ch.instr[11:7];
    rs_amt  = in_ch.rs_data[7:0];
    if (in_ch.instr[4]) begin
      keep = (rs_amt == 8'd0);
      rrx  = 1'b0;
      over = (rs_amt > 8'd32) && (kind == safe_pkg::SH_LSL || kind == safe_pkg::SH_LSR);
      if (kind == safe_pkg::SH_ROR) begin
        amt = {1'b0, rs_amt[4:0]};
      end else begin
        amt = (rs_amt > 8'd32) ? 6'd32 : rs_amt[5:0];
      end
    end else begin
      keep = (imm_amt == 5'd0) && (kind == safe_pkg::SH_LSL);
      rrx  = (imm_amt == 5'd0) && (kind == safe_pkg::SH_ROR);
      over = 1'b0;
      if (imm_amt == 5'd0 && (kind == safe_pkg::SH_LSR || kind == safe_pkg::SH_ASR)) begin
        amt = 6'd32;
      end else begin
        amt = {1'b0, imm_amt};
      end
    end
  end

  // Barrel shifts; for LSL, LSR and ASR the bit next to the result word is the carry out, ROR takes result bit 31
  always_comb begin
    lsl_t = {32'd0, in_ch.rm_data} << amt;
    lsr_t = {in_ch.rm_data, 32'd0} >> amt;
    asr_t = 64'($signed({in_ch.rm_data, 32'd0}) >>> amt);
    ror_t = {in_ch.rm_data, in_ch.rm_data} >> amt[4:0];
    imm_t = {24'd0, in_ch.instr[7:0], 24'd0, in_ch.instr[7:0]} >> {in_ch.instr[11:8], 1'b0};
  end

  // Select the shifter operand and carry
  always_comb begin
    priority if (in_ch.instr[25]) begin
      op = imm_t[31:0];
      sc = (in_ch.instr[11:8] == 4'd0) ? cin : imm_t[31];
    end else if (keep) begin
      op = in_ch.rm_data;
      sc = cin;
    end else if (over) begin
      op = 32'd0;
      sc = 1'b0;
    end else if (rrx) begin
      op = {cin, in_ch.rm_data[31:1]};
      sc = in_ch.rm_data[0];
    end else begin
      unique case (kind)
        safe_pkg::SH_LSL: begin
          op = lsl_t[31:0];
          sc = lsl_t[32];
        end
        safe_pkg::SH_LSR: begin
          op = lsr_t[63:32];
          sc = lsr_t[31];
        end
        safe_pkg::SH_ASR: begin
          op = asr_t[63:32];
          sc = asr_t[31];
        end
        default: begin
          op = ror_t[31:0];
          sc = ror_t[31];
        end
      endcase
    end
  end

  always_comb begin
    dn_next.opcode    = safe_pkg::alu_op_t'(in_ch.instr[24:21]);
    dn_next.s_bit     = in_ch.instr[20];
    dn_next.rd        = in_ch.instr[15:12];
    dn_next.rn        = in_ch.rn_data;
    dn_next.op        = op;
    dn_next.sc        = sc;
    dn_next.status    = in_ch.status_in;
    dn_next.saved     = in_ch.saved_status;
    dn_next.has_saved = in_ch.mode_has_saved;
  end

  // Advance when the next stage has room
  assign in_ch.ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (in_ch.ready) begin
      dn_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      dn <= dn_next;
    end
  end

  // Hold the stage while the ALU stage stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dn_valid && !dn_ready |=> dn_valid && $stable(dn))
    else $error("shift stage lost or changed a stalled transaction");

endmodule

### rtl/core/safe_alu.sv
module safe_alu (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   up_valid,
  output logic                   up_ready,
  input  safe_pkg::shift_stage_t up,
  output logic                   dn_valid,
  input  logic                   dn_ready,
  output safe_pkg::alu_stage_t   dn
);

  safe_pkg::alu_stage_t dn_next;
  logic [31:0]          a;
  logic [31:0]          b;
  logic                 cin;
  logic [32:0]          sum;
  logic                 arith;
  logic                 test;
  logic [31:0]          res;
  logic                 add_v;
  logic                 cflag;

  // Pick adder operands; subtraction adds the inverted operand
  always_comb begin
    cflag = up.status[safe_pkg::FlagC];
    arith = 1'b1;
    test  = 1'b0;
    unique case (up.opcode)
      safe_pkg::OP_SUB, safe_pkg::OP_CMP: begin
        a   = up.rn;
        b   = ~up.op;
        cin = 1'b1;
      end
      safe_pkg::OP_RSB: begin
        a   = up.op;
        b   = ~up.rn;
        cin = 1'b1;
      end
      safe_pkg::OP_ADD, safe_pkg::OP_CMN: begin
        a   = up.rn;
        b   = up.op;
        cin = 1'b0;
      end
      safe_pkg::OP_ADC: begin
        a   = up.rn;
        b   = up.op;
        cin = cflag;
      end
      safe_pkg::OP_SBC: begin
        a   = up.rn;
        b   = ~up.op;
        cin = cflag;
      end
      safe_pkg::OP_RSC: begin
        a   = up.op;
        b   = ~up.rn;
        cin = cflag;
      end
      default: begin
        a     = up.rn;
        b     = up.op;
        cin   = 1'b0;
        arith = 1'b0;
      end
    endcase
    if (up.opcode == safe_pkg::OP_TST || up.opcode == safe_pkg::OP_TEQ ||
        up.opcode == safe_pkg::OP_CMP || up.opcode == safe_pkg::OP_CMN) begin
      test = 1'b1;
    end
  end

  always_comb begin
    sum   = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    add_v = ((a[31] ^ sum[31]) & (b[31] ^ sum[31]));
  end

  // Select the ALU result
  always_comb begin
    unique case (up.opcode)
      safe_pkg::OP_AND, safe_pkg::OP_TST: res = up.rn & up.op;
      safe_pkg::OP_EOR, safe_pkg::OP_TEQ: res = up.rn ^ up.op;
      safe_pkg::OP_ORR:                   res = up.rn | up.op;
      safe_pkg::OP_MOV:                   res = up.op;
      safe_pkg::OP_BIC:                   res = up.rn & ~up.op;
      safe_pkg::OP_MVN:                   res = ~up.op;
      default:                            res = sum[31:0];
    endcase
  end

  // Logical opcodes take the shifter carry and keep V
  always_comb begin
    dn_next.test      = test;
    dn_next.s_bit     = up.s_bit;
    dn_next.rd        = up.rd;
    dn_next.res       = res;
    dn_next.c         = arith ? sum[32] : up.sc;
    dn_next.v         = arith ? add_v : up.status[safe_pkg::FlagV];
    dn_next.status    = up.status;
    dn_next.saved     = up.saved;
    dn_next.has_saved = up.has_saved;
  end

  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      dn <= dn_next;
    end
  end

  // Compare opcodes never reach the register file
  a_test: assert property (@(posedge clk) disable iff (rst)
    up_valid && up_ready && (up.opcode == safe_pkg::OP_CMP || up.opcode == safe_pkg::OP_CMN)
    |=> dn.test)
    else $error("compare opcode not marked as test");

endmodule

### rtl/core/safe_flags.sv
module safe_flags (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  safe_pkg::alu_stage_t up,
  safe_out_if.source           out_ch
);

  logic        wr_status;
  logic [31:0] status_next;

  // Build the new status word
  always_comb begin
    wr_status = up.s_bit || up.test;
    if (!wr_status) begin
      status_next = up.status;
    end else if (!up.test && up.rd == safe_pkg::RegPc && up.has_saved) begin
      status_next = up.saved;
    end else begin
      status_next = {up.res[31], (up.res == 32'd0), up.c, up.v, up.status[27:0]};
    end
  end

  assign up_ready = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (up_ready) begin
      out_ch.valid <= up_valid;
    end
  end

  // Load the output register
  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      out_ch.dest_index   <= up.rd;
      out_ch.dest_value   <= up.test ? 32'd0 : up.res;
      out_ch.dest_write   <= !up.test;
      out_ch.status_out   <= status_next;
      out_ch.status_write <= wr_status;
    end
  end

  a_test_zero: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.dest_write |-> out_ch.dest_value == 32'd0)
    else $error("test opcode produced a nonzero result");

  a_test_flags: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.dest_write |-> out_ch.status_write)
    else $error("test opcode did not update the status word");

endmodule

### rtl/core/shifter_alu_flags_execute_top.sv
// Data-processing execute unit: barrel shifter, 16-opcode ALU and NZCV flag
// update for one 32-bit instruction per transaction. It is a three-stage
// pipeline (shifter, adder/logic, flags and output register); each result is
// registered in those stages in that order, and one instruction is accepted
// every cycle while the output side takes results. The 33-bit adder in the
// middle stage sets the clock period. A stall on the output holds all three
// stages; ready drops only when every stage is full.
module shifter_alu_flags_execute_top (
  input  logic        clk,
  input  logic        rst,
  safe_in_if.sink     in_ch,
  safe_out_if.source  out_ch
);

  logic                   s1_valid;
  logic                   s1_ready;
  safe_pkg::shift_stage_t s1;
  logic                   s2_valid;
  logic                   s2_ready;
  safe_pkg::alu_stage_t   s2;

  safe_shift u_shift (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .dn_valid (s1_valid),
    .dn_ready (s1_ready),
    .dn       (s1)
  );

  safe_alu u_alu (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s1_valid),
    .up_ready (s1_ready),
    .up       (s1),
    .dn_valid (s2_valid),
    .dn_ready (s2_ready),
    .dn       (s2)
  );

  safe_flags u_flags (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up       (s2),
    .out_ch   (out_ch)
  );

  // Back-pressure reaches the input only when the whole pipe is full
  a_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> s1_valid && s2_valid && out_ch.valid && !out_ch.ready)
    else $error("input stalled with room in the pipeline");

endmodule

### tb/sv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 10;

  typedef struct packed {
    logic [31:0] instr;
    logic [31:0] rn_data;
    logic [31:0] rm_data;
    logic [31:0] rs_data;
    logic [31:0] status_in;
    logic [31:0] saved_status;
    logic        mode_has_saved;
  } exec_req_t;

  typedef struct packed {
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic        dest_write;
    logic [31:0] status_out;
    logic        status_write;
  } exec_res_t;

  logic clk;
  logic rst;

  safe_in_if  in_ch();
  safe_out_if out_ch();

  shifter_alu_flags_execute_top DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  exec_res_t   expected_results[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;

  // Status words used by the directed transactions
  localparam logic [31:0] StC     = 32'h2000_00D3;
  localparam logic [31:0] StClear = 32'h0000_0010;
  localparam logic [31:0] StAll   = 32'hF5A5_5A5A;
  localparam logic [31:0] Saved   = 32'h9000_001F;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] ror32(logic [31:0] x, logic [4:0] n);
    if (n == 5'd0) begin
      return x;
    end
    return (x >> n) | (x << (6'd32 - n));
  endfunction

  function automatic void barrel_shift(input logic [31:0] instr, input logic [31:0] rm,
                                       input logic [31:0] rs, input logic cin,
                                       output logic [31:0] op, output logic cout);
    safe_pkg::shift_kind_t kind;
    logic [4:0]  n;
    logic [7:0]  amt;
    logic [3:0]  rot;
    kind = safe_pkg::shift_kind_t'(instr[6:5]);
    n    = instr[11:7];
    amt  = rs[7:0];
    rot  = instr[11:8];
    if (instr[25]) begin
      // rotated 8-bit immediate
      op   = ror32({24'd0, instr[7:0]}, {rot, 1'b0});
      cout = (rot == 4'd0) ? cin : op[31];
    end else if (!instr[4]) begin
      // shift by immediate; zero amounts have their own meaning
      case (kind)
        safe_pkg::SH_LSL: begin
          if (n == 5'd0) begin
            op = rm; cout = cin;
          end else begin
            op = rm << n; cout = rm[32 - n];
          end
        end
        safe_pkg::SH_LSR: begin
          if (n == 5'd0) begin
            op = 32'd0; cout = rm[31];
          end else begin
            op = rm >> n; cout = rm[n - 1];
          end
        end
        safe_pkg::SH_ASR: begin
          if (n == 5'd0) begin
            op = {32{rm[31]}}; cout = rm[31];
          end else begin
            op = $signed(rm) >>> n; cout = rm[n - 1];
          end
        end
        default: begin
          if (n == 5'd0) begin
            op = {cin, rm[31:1]}; cout = rm[0];
          end else begin
            op = ror32(rm, n); cout = rm[n - 1];
          end
        end
      endcase
    end else if (amt == 8'd0) begin
      op = rm; cout = cin;
    end else begin
      // shift by the low byte of Rs
      case (kind)
        safe_pkg::SH_LSL: begin
          if (amt < 8'd32) begin
            op = rm << amt; cout = rm[32 - amt];
          end else if (amt == 8'd32) begin
            op = 32'd0; cout = rm[0];
          end else begin
            op = 32'd0; cout = 1'b0;
          end
        end
        safe_pkg::SH_LSR: begin
          if (amt < 8'd32) begin
            op = rm >> amt; cout = rm[amt - 1];
          end else if (amt == 8'd32) begin
            op = 32'd0; cout = rm[31];
          end else begin
            op = 32'd0; cout = 1'b0;
          end
        end
        safe_pkg::SH_ASR: begin
          if (amt < 8'd32) begin
            op = $signed(rm) >>> amt; cout = rm[amt - 1];
          end else begin
            op = {32{rm[31]}}; cout = rm[31];
          end
        end
        default: begin
          if (amt[4:0] == 5'd0) begin
            op = rm; cout = rm[31];
          end else begin
            op = ror32(rm, amt[4:0]); cout = rm[amt[4:0] - 1];
          end
        end
      endcase
    end
  endfunction

  function automatic logic [31:0] add_with_carry(input logic [31:0] a, input logic [31:0] b,
                                                 input logic cin, output logic c,
                                                 output logic v);
    logic [32:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
    c   = sum[32];
    v   = (a[31] ^ sum[31]) & (b[31] ^ sum[31]);
    return sum[31:0];
  endfunction

  function automatic exec_res_t predict_exec(exec_req_t q);
    safe_pkg::alu_op_t opc;
    logic [3:0]  rd;
    logic [31:0] rn, op, res, st;
    logic        cflag, sc, c, v, arith, test, s_bit;
    exec_res_t   r;
    opc   = safe_pkg::alu_op_t'(q.instr[24:21]);
    s_bit = q.instr[20];
    rd    = q.instr[15:12];
    rn    = q.rn_data;
    cflag = q.status_in[safe_pkg::FlagC];
    c     = 1'b0;
    v     = 1'b0;
    arith = 1'b0;
    test  = 1'b0;
    barrel_shift(q.instr, q.rm_data, q.rs_data, cflag, op, sc);

    case (opc)
      safe_pkg::OP_AND: res = rn & op;
      safe_pkg::OP_EOR: res = rn ^ op;
      safe_pkg::OP_SUB: begin res = add_with_carry(rn, ~op, 1'b1, c, v); arith = 1'b1; end
      safe_pkg::OP_RSB: begin res = add_with_carry(op, ~rn, 1'b1, c, v); arith = 1'b1; end
      safe_pkg::OP_ADD: begin res = add_with_carry(rn, op, 1'b0, c, v); arith = 1'b1; end
      safe_pkg::OP_ADC: begin res = add_with_carry(rn, op, cflag, c, v); arith = 1'b1; end
      safe_pkg::OP_SBC: begin res = add_with_carry(rn, ~op, cflag, c, v); arith = 1'b1; end
      safe_pkg::OP_RSC: begin res = add_with_carry(op, ~rn, cflag, c, v); arith = 1'b1; end
      safe_pkg::OP_TST: begin res = rn & op; test = 1'b1; end
      safe_pkg::OP_TEQ: begin res = rn ^ op; test = 1'b1; end
      safe_pkg::OP_CMP: begin
        res = add_with_carry(rn, ~op, 1'b1, c, v); arith = 1'b1; test = 1'b1;
      end
      safe_pkg::OP_CMN: begin
        res = add_with_carry(rn, op, 1'b0, c, v); arith = 1'b1; test = 1'b1;
      end
      safe_pkg::OP_ORR: res = rn | op;
      safe_pkg::OP_MOV: res = op;
      safe_pkg::OP_BIC: res = rn & ~op;
      default: res = ~op;
    endcase

    // Flags, when written: restore from saved status on a non-test PC write with one, else recompute NZCV
    st = q.status_in;
    if (s_bit || test) begin
      if (!test && rd == safe_pkg::RegPc && q.mode_has_saved) begin
        st = q.saved_status;
      end else begin
        if (!arith) begin
          c = sc;
          v = q.status_in[safe_pkg::FlagV];
        end
        st[safe_pkg::FlagN] = res[31];
        st[safe_pkg::FlagZ] = (res == 32'd0);
        st[safe_pkg::FlagC] = c;
        st[safe_pkg::FlagV] = v;
      end
    end

    r.dest_index   = rd;
    r.dest_value   = test ? 32'd0 : res;
    r.dest_write   = !test;
    r.status_out   = st;
    r.status_write = s_bit || test;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Predict on input transactions, compare on output transactions, watch for hangs
  always @(posedge clk) begin : scoreboard
    exec_req_t seen;
    exec_res_t got;
    exec_res_t want;
    logic      moved;
    moved = 1'b0;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        seen = '{in_ch.instr, in_ch.rn_data, in_ch.rm_data, in_ch.rs_data,
                 in_ch.status_in, in_ch.saved_status, in_ch.mode_has_saved};
        expected_results.push_back(predict_exec(seen));
        moved = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        got = '{out_ch.dest_index, out_ch.dest_value, out_ch.dest_write,
                out_ch.status_out, out_ch.status_write};
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: dest_value %h",
                                    got.dest_value));
        end else begin
          want = expected_results.pop_front();
          if (got.dest_index !== want.dest_index)
            report_mismatch($sformatf("dest_index got %h expected %h",
                                      got.dest_index, want.dest_index));
          if (got.dest_value !== want.dest_value)
            report_mismatch($sformatf("dest_value got %h expected %h",
                                      got.dest_value, want.dest_value));
          if (got.dest_write !== want.dest_write)
            report_mismatch($sformatf("dest_write got %b expected %b",
                                      got.dest_write, want.dest_write));
          if (got.status_out !== want.status_out)
            report_mismatch($sformatf("status_out got %h expected %h",
                                      got.status_out, want.status_out));
          if (got.status_write !== want.status_write)
            report_mismatch($sformatf("status_write got %b expected %b",
                                      got.status_write, want.status_write));
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Stall the output side at random
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
  end

  // Hold one transaction on the input until it is taken, after a random gap
  task automatic send_item(exec_req_t q);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.instr          <= q.instr;
    in_ch.rn_data        <= q.rn_data;
    in_ch.rm_data        <= q.rm_data;
    in_ch.rs_data        <= q.rs_data;
    in_ch.status_in      <= q.status_in;
    in_ch.saved_status   <= q.saved_status;
    in_ch.mode_has_saved <= q.mode_has_saved;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  function automatic exec_req_t make_req(logic [31:0] instr, logic [31:0] rn,
                                         logic [31:0] rm, logic [31:0] rs,
                                         logic [31:0] st, logic [31:0] saved = 32'd0,
                                         logic has_saved = 1'b0);
    return '{instr, rn, rm, rs, st, saved, has_saved};
  endfunction

  // Data-processing encoding with condition "always" and Rn field 1
  function automatic logic [31:0] dp(safe_pkg::alu_op_t op, logic s, logic [3:0] rd,
                                     logic imm, logic [11:0] sh);
    return {4'hE, 2'b00, imm, op, s, 4'h1, rd, sh};
  endfunction

  // Shift by immediate: amount 11..7, kind 6..5, bit 4 clear, Rm 3..0
  function automatic logic [11:0] sh_imm(logic [4:0] n, safe_pkg::shift_kind_t k);
    return {n, k, 1'b0, 4'd0};
  endfunction

  // Shift by register: Rs 11..8, bit 7 clear, kind 6..5, bit 4 set, Rm 3..0
  function automatic logic [11:0] sh_reg(safe_pkg::shift_kind_t k);
    return {4'h2, 1'b0, k, 1'b1, 4'd0};
  endfunction

  task automatic test_shifter_forms();
    // rotated immediates: no rotation keeps C, rotation takes bit 31
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd1, 1'b1, {4'd0, 8'hA5}),
                       0, 0, 0, StC));
    send_item(make_req(dp(safe_pkg::OP_MVN, 1'b1, 4'd2, 1'b1, {4'd1, 8'h03}),
                       0, 0, 0, StClear));
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd3, 1'b1, {4'd15, 8'hFF}),
                       0, 0, 0, StC));
    // immediate shifts, zero and maximum amounts
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd4, 1'b0,
                          sh_imm(5'd0, safe_pkg::SH_LSL)), 0, '1, 0, StClear));
    send_item(make_req(dp(safe_pkg::OP_AND, 1'b1, 4'd5, 1'b0,
                          sh_imm(5'd31, safe_pkg::SH_LSL)), '1, 32'd3, 0, StAll));
    send_item(make_req(dp(safe_pkg::OP_EOR, 1'b1, 4'd6, 1'b0,
                          sh_imm(5'd0, safe_pkg::SH_LSR)), 32'h1234_5678,
                       32'h8000_0000, 0, StClear));
    send_item(make_req(dp(safe_pkg::OP_BIC, 1'b1, 4'd7, 1'b0,
                          sh_imm(5'd0, safe_pkg::SH_ASR)), '1,
                       32'h8000_0001, 0, StClear));
    // rotate by zero is RRX
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd8, 1'b0,
                          sh_imm(5'd0, safe_pkg::SH_ROR)), 0, 32'd1, 0, StC));
    send_item(make_req(dp(safe_pkg::OP_ORR, 1'b1, 4'd9, 1'b0,
                          sh_imm(5'd31, safe_pkg::SH_ROR)), 0,
                       32'h4000_0000, 0, StClear));
    // register shifts: zero, exactly 32, beyond 32, with bit 7 set
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd10, 1'b0, sh_reg(safe_pkg::SH_LSL)),
                       0, 32'h55, 32'h100, StC));
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd11, 1'b0, sh_reg(safe_pkg::SH_LSL)),
                       0, 32'd1, 32'd32, StClear));
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd12, 1'b0,
                          sh_reg(safe_pkg::SH_LSL) | 12'h080), 0, '1, 32'hFF, StC));
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd13, 1'b0, sh_reg(safe_pkg::SH_LSR)),
                       0, 32'h8000_0000, 32'd32, StClear));
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd14, 1'b0, sh_reg(safe_pkg::SH_ASR)),
                       0, 32'h8000_0000, 32'd40, StClear));
    send_item(make_req(dp(safe_pkg::OP_MOV, 1'b1, 4'd0, 1'b0, sh_reg(safe_pkg::SH_ROR)),
                       0, 32'h8000_0000, 32'd64, StClear));
  endtask

  task automatic test_alu_ops();
    // subtract below zero clears C; add past all ones wraps to zero
    send_item(make_req(dp(safe_pkg::OP_SUB, 1'b1, 4'd1, 1'b1, {4'd0, 8'd1}),
                       0, 0, 0, StC));
    send_item(make_req(dp(safe_pkg::OP_ADD, 1'b1, 4'd2, 1'b1, {4'd0, 8'd1}),
                       '1, 0, 0, StClear));
    // SBC with C clear borrows one more and overflows
    send_item(make_req(dp(safe_pkg::OP_SBC, 1'b1, 4'd3, 1'b1, {4'd0, 8'd0}),
                       32'h8000_0000, 0, 0, StClear));
    send_item(make_req(dp(safe_pkg::OP_CMP, 1'b1, 4'd4, 1'b0,
                          sh_imm(5'd0, safe_pkg::SH_LSL)), 32'h7FFF_FFFF,
                       '1, 0, StClear));
    send_item(make_req(dp(safe_pkg::OP_CMN, 1'b0, 4'd5, 1'b1, {4'd0, 8'd1}),
                       32'h7FFF_FFFF, 0, 0, StC));
  endtask

  task automatic test_status_rules();
    // RSBS to PC with a saved status restores it
    send_item(make_req(dp(safe_pkg::OP_RSB, 1'b1, safe_pkg::RegPc, 1'b1, {4'd0, 8'd7}),
                       32'd3, 0, 0, StC, Saved, 1'b1));
    // no S bit: status passes through
    send_item(make_req(dp(safe_pkg::OP_ADC, 1'b0, 4'd6, 1'b1, {4'd0, 8'd0}),
                       32'h7FFF_FFFF, 0, 0, StC));
    // RSCS to PC without a saved status computes flags
    send_item(make_req(dp(safe_pkg::OP_RSC, 1'b1, safe_pkg::RegPc, 1'b1, {4'd0, 8'd0}),
                       32'd5, 0, 0, StC, Saved, 1'b0));
    // TST without S still writes flags
    send_item(make_req(dp(safe_pkg::OP_TST, 1'b0, 4'd7, 1'b1, {4'd0, 8'hF0}),
                       32'h0F, 0, 0, StAll));
    // TEQ to PC never restores the saved status
    send_item(make_req(dp(safe_pkg::OP_TEQ, 1'b1, safe_pkg::RegPc, 1'b1, {4'd0, 8'h01}),
                       32'd1, 0, 0, StAll, Saved, 1'b1));
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7FFF_FFFF;
      4: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_random_traffic(int unsigned count);
    exec_req_t q;
    repeat (count) begin
      q.instr          = $urandom;
      q.rn_data        = pick_word();
      q.rm_data        = pick_word();
      q.rs_data        = $urandom;
      q.status_in      = $urandom;
      q.saved_status   = $urandom;
      q.mode_has_saved = 1'($urandom_range(1));
      // steer toward PC writes, boundary shift amounts and equal operands
      if ($urandom_range(4) == 0) q.instr[15:12] = safe_pkg::RegPc;
      if ($urandom_range(1) == 0) q.rs_data[7:0] = 8'($urandom_range(0, 40));
      if ($urandom_range(7) == 0) q.rn_data = q.rm_data;
      send_item(q);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    src_idle_pct         = 12;
    snk_stall_pct        = 62;
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.instr          <= '0;
    in_ch.rn_data        <= '0;
    in_ch.rm_data        <= '0;
    in_ch.rs_data        <= '0;
    in_ch.status_in      <= '0;
    in_ch.saved_status   <= '0;
    in_ch.mode_has_saved <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_shifter_forms();
    test_alu_ops();
    test_status_rules();
    test_random_traffic(500);

    src_idle_pct  = 62;
    snk_stall_pct = 12;
    test_random_traffic(500);

    src_idle_pct  = 0;
    snk_stall_pct = 0;
    test_random_traffic(500);

    // drain the pipeline, then watch for stray results
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/safe_pkg.sv
rtl/core/safe_in_if.sv
rtl/core/safe_out_if.sv
rtl/core/safe_shift.sv
rtl/core/safe_alu.sv
rtl/core/safe_flags.sv
rtl/core/shifter_alu_flags_execute_top.sv
tb/sv/tb_top.sv
